/* sv/closest_point_on_triangle_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the closest point on triangle block
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_TRIANGLE_TOP_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CPT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define CPT_ASSERT(lbl, prop, msg)
`define CPT_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* sv/cpt_pkg.sv */
// ----------------------------------------------------------------------------
// Closest point on triangle package
// Shared constants and the region code type.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int WEIGHT_BITS = 16;
  localparam int WEIGHT_W    = WEIGHT_BITS + 1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_BITS;
  localparam int MUL_CHUNK   = 32;
  localparam int DIST_W      = 64;

  typedef enum logic [2:0] {
    RGN_A    = 3'd0,
    RGN_B    = 3'd1,
    RGN_C    = 3'd2,
    RGN_AB   = 3'd3,
    RGN_AC   = 3'd4,
    RGN_BC   = 3'd5,
    RGN_FACE = 3'd6
  } region_e;

endpackage

/* sv/cpt_ctrl.sv */
// ----------------------------------------------------------------------------
// Pipeline control
// Valid bits for every stage and per-stage load enables that let bubbles
// collapse while the output side stalls.
// ----------------------------------------------------------------------------
`include "closest_point_on_triangle_top_assert.svh"

module cpt_ctrl #(
  parameter int N = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         stall_o,
  output logic         valid_o,
  input  logic         stall_i,
  output logic [N-1:0] en_o
);

  logic [N-1:0] v_q, v_d;

  // A stage may load when the output is free or some stage at or after it is empty.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      en_o[k] = !stall_i || ((v_q | ({N{1'b1}} >> (N - k))) != {N{1'b1}});
    end
    v_d = (en_o & {v_q[N-2:0], valid_i}) | (~en_o & v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign stall_o = !en_o[0];
  assign valid_o = v_q[N-1];

  `CPT_ASSERT_NEVER(a_stall_with_gap, stall_o && !(&v_q), "input stalled with a free stage")
  `CPT_ASSERT(a_free_out_no_stall, !stall_i |-> !stall_o, "input stalled while output is free")
  `CPT_ASSERT(a_accept_enters, valid_i && !stall_o |=> v_q[0], "accepted transfer was lost")

endmodule

/* sv/cpt_dly.sv */
// ----------------------------------------------------------------------------
// Stage-aligned delay line
// Carries a value through N pipeline stages, each with its own load enable.
// ----------------------------------------------------------------------------
module cpt_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic [N-1:0] en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] s_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s_q[0] <= d_i;
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        s_q[k] <= s_q[k-1];
      end
    end
  end

  assign q_o = s_q[N-1];

endmodule

/* sv/cpt_mul.sv */
// ----------------------------------------------------------------------------
// Two-stage signed multiplier
// Operands are split into chunks; chunk products are registered, then summed.
// ----------------------------------------------------------------------------
module cpt_mul
  import cpt_pkg::*;
#(
  parameter int W = 33
) (
  input  logic                  clk_i,
  input  logic [1:0]            en_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  localparam int CH = MUL_CHUNK;
  localparam int NC = (W + CH - 1) / CH;
  localparam int XW = NC * CH;
  localparam int FW = 2 * XW;

  logic signed [XW-1:0]     ae, be;
  logic signed [CH:0]       ca [NC];
  logic signed [CH:0]       cb [NC];
  logic signed [2*CH+1:0]   pp_q [NC*NC];
  logic signed [FW-1:0]     acc;
  logic signed [2*W-1:0]    p_q;

  assign ae = XW'(a_i);
  assign be = XW'(b_i);

  // The top chunk carries the sign, lower chunks are unsigned.
  for (genvar i = 0; i < NC; i++) begin : g_chunk
    if (i == NC - 1) begin : g_top
      assign ca[i] = {ae[XW-1], ae[i*CH +: CH]};
      assign cb[i] = {be[XW-1], be[i*CH +: CH]};
    end else begin : g_low
      assign ca[i] = {1'b0, ae[i*CH +: CH]};
      assign cb[i] = {1'b0, be[i*CH +: CH]};
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_row
    for (genvar j = 0; j < NC; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en_i[0]) begin
          pp_q[i*NC+j] <= ca[i] * cb[j];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NC; j++) begin
        acc = acc + (FW'(pp_q[i*NC+j]) << ((i + j) * CH));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q <= acc[2*W-1:0];
    end
  end

  assign p_o = p_q;

endmodule

/* sv/cpt_div.sv */
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Computes floor(num * 2^16 / den) clamped to [0, one], one quotient bit a stage.
// ----------------------------------------------------------------------------
module cpt_div
  import cpt_pkg::*;
#(
  parameter int NW = 139
) (
  input  logic                   clk_i,
  input  logic [WEIGHT_BITS:0]   en_i,
  input  logic signed [NW-1:0]   num_i,
  input  logic signed [NW-1:0]   den_i,
  output logic [WEIGHT_W-1:0]    q_o
);

  localparam int WB = WEIGHT_BITS;

  logic [NW-1:0] r_q   [WB+1];
  logic [NW-1:0] den_q [WB+1];
  logic [WB-1:0] q_q   [WB+1];
  logic          zero_q [WB+1];
  logic          one_q  [WB+1];

  // Clamp flags are decided up front; the iterations run regardless.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q[0]    <= num_i;
      den_q[0]  <= den_i;
      q_q[0]    <= '0;
      zero_q[0] <= num_i <= 0;
      one_q[0]  <= ((NW+1)'(num_i) - (NW+1)'(den_i)) >= 0;
    end
  end

  for (genvar k = 1; k <= WB; k++) begin : g_iter
    logic [NW:0] r2, t;
    assign r2 = {r_q[k-1], 1'b0};
    assign t  = r2 - {1'b0, den_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        r_q[k]    <= t[NW] ? r2[NW-1:0] : t[NW-1:0];
        q_q[k]    <= {q_q[k-1][WB-2:0], !t[NW]};
        den_q[k]  <= den_q[k-1];
        zero_q[k] <= zero_q[k-1];
        one_q[k]  <= one_q[k-1];
      end
    end
  end

  assign q_o = zero_q[WB] ? '0 : (one_q[WB] ? WEIGHT_ONE : {1'b0, q_q[WB]});

endmodule

/* sv/closest_point_on_triangle_top.sv */
// ----------------------------------------------------------------------------
// Closest point on triangle
// Classifies a query point against a triangle and returns the nearest point.
// ----------------------------------------------------------------------------
// Usage: each input transfer on valid_i/stall_o carries three vertices and a
// query point in signed fixed point. Each accepted transfer yields exactly one
// output transfer on valid_o/stall_i with the closest point, barycentric
// weights (65536 is one), squared distance in Q32.32 saturating, the Voronoi
// region code and a degenerate flag.
// Throughput is one transfer per cycle while stall_o is low, over 32 register
// stages: differences, two multiplier stages and a sum for the dot products,
// two more multiplier stages for the cross terms, numerators, classification,
// a 17-stage divider, weighting, products, point, offset, two square stages
// and distance.
// Reset clears every valid bit; data registers are not reset.
// When stall_i is high the output holds and stages behind it keep filling
// until every stage is occupied; only then is stall_o raised.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_top
  import cpt_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [COORD_WIDTH-1:0] vert_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] vert_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] vert_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] vert_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] vert_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] vert_b_z_i,
  input  logic signed [COORD_WIDTH-1:0] vert_c_x_i,
  input  logic signed [COORD_WIDTH-1:0] vert_c_y_i,
  input  logic signed [COORD_WIDTH-1:0] vert_c_z_i,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  input  logic signed [COORD_WIDTH-1:0] query_z_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic signed [COORD_WIDTH-1:0] near_x_o,
  output logic signed [COORD_WIDTH-1:0] near_y_o,
  output logic signed [COORD_WIDTH-1:0] near_z_o,
  output logic [WEIGHT_W-1:0]           weight_a_o,
  output logic [WEIGHT_W-1:0]           weight_b_o,
  output logic [WEIGHT_W-1:0]           weight_c_o,
  output logic [DIST_W-1:0]             dist_sq_o,
  output logic [2:0]                    region_o,
  output logic                          degenerate_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int DIF = CW + 1;
  localparam int PW  = 2 * DIF;
  localparam int DW  = PW + 2;
  localparam int VW  = 2 * DW + 1;
  localparam int NW  = VW + 2;
  localparam int PRW = DIF + WEIGHT_W + 1;
  localparam int SW  = PW + 2;
  localparam int XSW = SW + 32;
  localparam int NST = 32;
  localparam int WB  = WEIGHT_BITS;
  localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int MB [6] = '{3, 1, 1, 5, 5, 3};
  localparam int OW = 3 * WEIGHT_W + 4;

  logic [NST-1:0] en;

  cpt_ctrl #(.N(NST)) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .en_o    (en)
  );

  // Stage 0: edge and offset vectors.
  logic signed [CW-1:0]  ar [3];
  logic signed [CW-1:0]  br [3];
  logic signed [CW-1:0]  cr [3];
  logic signed [CW-1:0]  pr [3];
  logic signed [DIF-1:0] ab_q [3];
  logic signed [DIF-1:0] ac_q [3];
  logic signed [DIF-1:0] bc_q [3];
  logic signed [DIF-1:0] ap_q [3];
  logic signed [DIF-1:0] bp_q [3];
  logic signed [DIF-1:0] cp_q [3];

  assign ar = '{vert_a_x_i, vert_a_y_i, vert_a_z_i};
  assign br = '{vert_b_x_i, vert_b_y_i, vert_b_z_i};
  assign cr = '{vert_c_x_i, vert_c_y_i, vert_c_z_i};
  assign pr = '{query_x_i, query_y_i, query_z_i};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        ab_q[i] <= DIF'(br[i]) - DIF'(ar[i]);
        ac_q[i] <= DIF'(cr[i]) - DIF'(ar[i]);
        bc_q[i] <= DIF'(cr[i]) - DIF'(br[i]);
        ap_q[i] <= DIF'(pr[i]) - DIF'(ar[i]);
        bp_q[i] <= DIF'(pr[i]) - DIF'(br[i]);
        cp_q[i] <= DIF'(pr[i]) - DIF'(cr[i]);
      end
    end
  end

  // Vertices and query point travel alongside.
  logic [3*CW-1:0] a24, b24, c24, p27;
  logic [3*DIF-1:0] ab24, ac24, bc24;

  cpt_dly #(.W(3*CW), .N(25)) u_dly_a (.clk_i(clk_i), .en_i(en[24:0]),
    .d_i({ar[2], ar[1], ar[0]}), .q_o(a24));
  cpt_dly #(.W(3*CW), .N(25)) u_dly_b (.clk_i(clk_i), .en_i(en[24:0]),
    .d_i({br[2], br[1], br[0]}), .q_o(b24));
  cpt_dly #(.W(3*CW), .N(25)) u_dly_c (.clk_i(clk_i), .en_i(en[24:0]),
    .d_i({cr[2], cr[1], cr[0]}), .q_o(c24));
  cpt_dly #(.W(3*CW), .N(28)) u_dly_p (.clk_i(clk_i), .en_i(en[27:0]),
    .d_i({pr[2], pr[1], pr[0]}), .q_o(p27));
  cpt_dly #(.W(3*DIF), .N(24)) u_dly_ab (.clk_i(clk_i), .en_i(en[24:1]),
    .d_i({ab_q[2], ab_q[1], ab_q[0]}), .q_o(ab24));
  cpt_dly #(.W(3*DIF), .N(24)) u_dly_ac (.clk_i(clk_i), .en_i(en[24:1]),
    .d_i({ac_q[2], ac_q[1], ac_q[0]}), .q_o(ac24));
  cpt_dly #(.W(3*DIF), .N(24)) u_dly_bc (.clk_i(clk_i), .en_i(en[24:1]),
    .d_i({bc_q[2], bc_q[1], bc_q[0]}), .q_o(bc24));

  // Stages 1-2: per-axis products of the six dot products.
  logic signed [PW-1:0] dprod [6][3];

  for (genvar j = 0; j < 6; j++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_axis
      cpt_mul #(.W(DIF)) u_mul (
        .clk_i (clk_i),
        .en_i  (en[2:1]),
        .a_i   ((j % 2 == 0) ? ab_q[i] : ac_q[i]),
        .b_i   ((j / 2 == 0) ? ap_q[i] : ((j / 2 == 1) ? bp_q[i] : cp_q[i])),
        .p_o   (dprod[j][i])
      );
    end
  end

  // Stage 3: dot sums d1..d6.
  logic signed [DW-1:0] dot_q [6];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int j = 0; j < 6; j++) begin
        dot_q[j] <= DW'(dprod[j][0]) + DW'(dprod[j][1]) + DW'(dprod[j][2]);
      end
    end
  end

  // Stages 4-5: cross terms of the dot products.
  logic signed [2*DW-1:0] mprod [6];

  for (genvar k = 0; k < 6; k++) begin : g_cross
    cpt_mul #(.W(DW)) u_mul (
      .clk_i (clk_i),
      .en_i  (en[5:4]),
      .a_i   (dot_q[MA[k]]),
      .b_i   (dot_q[MB[k]]),
      .p_o   (mprod[k])
    );
  end

  logic signed [DW:0]   d13_q, d26_q, d43_q, d56_q;
  logic signed [DW+1:0] e5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      d13_q <= (DW+1)'(dot_q[0]) - (DW+1)'(dot_q[2]);
      d26_q <= (DW+1)'(dot_q[1]) - (DW+1)'(dot_q[5]);
      d43_q <= (DW+1)'(dot_q[3]) - (DW+1)'(dot_q[2]);
      d56_q <= (DW+1)'(dot_q[4]) - (DW+1)'(dot_q[5]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      e5_q <= (DW+2)'(d43_q) + (DW+2)'(d56_q);
    end
  end

  logic [6*DW-1:0]     dotp6;
  logic [4*(DW+1)-1:0] dif6;
  logic [DW+1:0]       e5p6;

  cpt_dly #(.W(6*DW), .N(3)) u_dly_dot (.clk_i(clk_i), .en_i(en[6:4]),
    .d_i({dot_q[5], dot_q[4], dot_q[3], dot_q[2], dot_q[1], dot_q[0]}), .q_o(dotp6));
  cpt_dly #(.W(4*(DW+1)), .N(2)) u_dly_dif (.clk_i(clk_i), .en_i(en[6:5]),
    .d_i({d56_q, d43_q, d26_q, d13_q}), .q_o(dif6));
  cpt_dly #(.W(DW+2), .N(1)) u_dly_e5 (.clk_i(clk_i), .en_i(en[6:6]),
    .d_i(e5_q), .q_o(e5p6));

  // Stage 6: barycentric numerators.
  logic signed [VW-1:0] va_q, vb_q, vc_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      vc_q <= VW'(mprod[0]) - VW'(mprod[1]);
      vb_q <= VW'(mprod[2]) - VW'(mprod[3]);
      va_q <= VW'(mprod[4]) - VW'(mprod[5]);
    end
  end

  // Stage 7: region classification and divider operands.
  logic signed [DW-1:0]   dd [6];
  logic signed [DW:0]     x13, x26, x43, x56;
  logic signed [DW+1:0]   e5s;
  logic signed [NW-1:0]   vsum, num0_d, num1_d, den_d;
  logic signed [NW-1:0]   num0_q, num1_q, den_q;
  region_e                rgn7_d, rgn7_q;

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      dd[j] = $signed(dotp6[j*DW +: DW]);
    end
    x13  = $signed(dif6[0 +: DW+1]);
    x26  = $signed(dif6[(DW+1) +: DW+1]);
    x43  = $signed(dif6[2*(DW+1) +: DW+1]);
    x56  = $signed(dif6[3*(DW+1) +: DW+1]);
    e5s  = $signed(e5p6);
    vsum = NW'(va_q) + NW'(vb_q) + NW'(vc_q);
    num0_d = NW'(vb_q);
    num1_d = NW'(vc_q);
    den_d  = vsum;
    if (dd[0] <= 0 && dd[1] <= 0) begin
      rgn7_d = RGN_A;
    end else if (dd[2] >= 0 && x43 <= 0) begin
      rgn7_d = RGN_B;
    end else if (dd[5] >= 0 && x56 <= 0) begin
      rgn7_d = RGN_C;
    end else if (vc_q <= 0 && dd[0] >= 0 && dd[2] <= 0) begin
      rgn7_d = RGN_AB;
      num0_d = NW'(dd[0]);
      den_d  = NW'(x13);
    end else if (vb_q <= 0 && dd[1] >= 0 && dd[5] <= 0) begin
      rgn7_d = RGN_AC;
      num0_d = NW'(dd[1]);
      den_d  = NW'(x26);
    end else if (va_q <= 0 && x43 >= 0 && x56 >= 0) begin
      rgn7_d = RGN_BC;
      num0_d = NW'(x43);
      den_d  = NW'(e5s);
    end else begin
      rgn7_d = RGN_FACE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      rgn7_q <= rgn7_d;
      num0_q <= num0_d;
      num1_q <= num1_d;
      den_q  <= den_d;
    end
  end

  // Stage 8: a non-positive divisor falls back to vertex a.
  region_e rgn8_q;
  logic    dg8_q;
  logic    div_region;

  assign div_region = (rgn7_q == RGN_AB) || (rgn7_q == RGN_AC) ||
                      (rgn7_q == RGN_BC) || (rgn7_q == RGN_FACE);

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      dg8_q  <= div_region && (den_q <= 0);
      rgn8_q <= (div_region && (den_q <= 0)) ? RGN_A : rgn7_q;
    end
  end

  // Stages 8-24: two dividers in parallel.
  logic [WEIGHT_W-1:0] t0, t1;

  cpt_div #(.NW(NW)) u_div0 (
    .clk_i (clk_i),
    .en_i  (en[24:8]),
    .num_i (num0_q),
    .den_i (den_q),
    .q_o   (t0)
  );

  cpt_div #(.NW(NW)) u_div1 (
    .clk_i (clk_i),
    .en_i  (en[24:8]),
    .num_i (num1_q),
    .den_i (den_q),
    .q_o   (t1)
  );

  logic [3:0] rd24;

  cpt_dly #(.W(4), .N(16)) u_dly_rgn (.clk_i(clk_i), .en_i(en[24:9]),
    .d_i({rgn8_q, dg8_q}), .q_o(rd24));

  // Stage 25: weights, base point and blend directions.
  logic signed [CW-1:0]  base_d [3];
  logic signed [DIF-1:0] dir1_d [3];
  logic signed [DIF-1:0] dir2_d [3];
  logic [WEIGHT_W-1:0]   c1_d, c2_d, wa_d, wb_d, wc_d, wf;
  logic [WEIGHT_W:0]     vw_sum;
  logic signed [CW-1:0]  base_q [3];
  logic signed [DIF-1:0] dir1_q [3];
  logic signed [DIF-1:0] dir2_q [3];
  logic [WEIGHT_W-1:0]   c1_q, c2_q, wa_q, wb_q, wc_q;
  logic [3:0]            rd25_q;

  always_comb begin
    vw_sum = (WEIGHT_W+1)'(t0) + (WEIGHT_W+1)'(t1);
    wf     = (vw_sum > (WEIGHT_W+1)'(WEIGHT_ONE)) ? WEIGHT_ONE - t0 : t1;
    c1_d   = '0;
    c2_d   = '0;
    wa_d   = WEIGHT_ONE;
    wb_d   = '0;
    wc_d   = '0;
    for (int i = 0; i < 3; i++) begin
      base_d[i] = $signed(a24[i*CW +: CW]);
      dir1_d[i] = $signed(ab24[i*DIF +: DIF]);
      dir2_d[i] = $signed(ac24[i*DIF +: DIF]);
    end
    unique case (region_e'(rd24[3:1]))
      RGN_A: begin
      end
      RGN_B: begin
        for (int i = 0; i < 3; i++) base_d[i] = $signed(b24[i*CW +: CW]);
        wa_d = '0;
        wb_d = WEIGHT_ONE;
      end
      RGN_C: begin
        for (int i = 0; i < 3; i++) base_d[i] = $signed(c24[i*CW +: CW]);
        wa_d = '0;
        wc_d = WEIGHT_ONE;
      end
      RGN_AB: begin
        c1_d = t0;
        wa_d = WEIGHT_ONE - t0;
        wb_d = t0;
      end
      RGN_AC: begin
        for (int i = 0; i < 3; i++) dir1_d[i] = $signed(ac24[i*DIF +: DIF]);
        c1_d = t0;
        wa_d = WEIGHT_ONE - t0;
        wc_d = t0;
      end
      RGN_BC: begin
        for (int i = 0; i < 3; i++) begin
          base_d[i] = $signed(b24[i*CW +: CW]);
          dir1_d[i] = $signed(bc24[i*DIF +: DIF]);
        end
        c1_d = t0;
        wa_d = '0;
        wb_d = WEIGHT_ONE - t0;
        wc_d = t0;
      end
      RGN_FACE: begin
        c1_d = t0;
        c2_d = wf;
        wa_d = WEIGHT_ONE - t0 - wf;
        wb_d = t0;
        wc_d = wf;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[25]) begin
      base_q <= base_d;
      dir1_q <= dir1_d;
      dir2_q <= dir2_d;
      c1_q   <= c1_d;
      c2_q   <= c2_d;
      wa_q   <= wa_d;
      wb_q   <= wb_d;
      wc_q   <= wc_d;
      rd25_q <= rd24;
    end
  end

  // Stage 26: weight times direction.
  logic signed [PRW-1:0] pr1_q [3];
  logic signed [PRW-1:0] pr2_q [3];
  logic signed [CW-1:0]  base26_q [3];

  always_ff @(posedge clk_i) begin
    if (en[26]) begin
      for (int i = 0; i < 3; i++) begin
        pr1_q[i] <= $signed({1'b0, c1_q}) * dir1_q[i];
        pr2_q[i] <= $signed({1'b0, c2_q}) * dir2_q[i];
      end
      base26_q <= base_q;
    end
  end

  // Stage 27: closest point.
  logic signed [PRW:0]  nsum [3];
  logic signed [PRW:0]  nsh  [3];
  logic signed [CW-1:0] near_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsum[i] = (PRW+1)'(pr1_q[i]) + (PRW+1)'(pr2_q[i]);
      nsh[i]  = nsum[i] >>> WB;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[27]) begin
      for (int i = 0; i < 3; i++) begin
        near_q[i] <= base26_q[i] + nsh[i][CW-1:0];
      end
    end
  end

  // Stage 28: offset from the closest point to the query.
  logic signed [DIF-1:0] dq_q [3];
  logic signed [CW-1:0]  p27s [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p27s[i] = $signed(p27[i*CW +: CW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[28]) begin
      for (int i = 0; i < 3; i++) begin
        dq_q[i] <= DIF'(p27s[i]) - DIF'(near_q[i]);
      end
    end
  end

  // Stages 29-30: squares.
  logic signed [PW-1:0] sq [3];

  for (genvar i = 0; i < 3; i++) begin : g_sq
    cpt_mul #(.W(DIF)) u_mul (
      .clk_i (clk_i),
      .en_i  (en[30:29]),
      .a_i   (dq_q[i]),
      .b_i   (dq_q[i]),
      .p_o   (sq[i])
    );
  end

  // Stage 31: scale to 32 fraction bits and saturate.
  logic signed [SW-1:0] ssum;
  logic [XSW-1:0]       sext;
  logic [DIST_W-1:0]    dist_q;

  assign ssum = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
  assign sext = {ssum, 32'b0} >> (2 * FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en[31]) begin
      dist_q <= (|sext[XSW-1:DIST_W]) ? '1 : sext[DIST_W-1:0];
    end
  end

  logic [3*CW-1:0] near31;
  logic [OW-1:0]   ow31;

  cpt_dly #(.W(3*CW), .N(4)) u_dly_near (.clk_i(clk_i), .en_i(en[31:28]),
    .d_i({near_q[2], near_q[1], near_q[0]}), .q_o(near31));
  cpt_dly #(.W(OW), .N(6)) u_dly_out (.clk_i(clk_i), .en_i(en[31:26]),
    .d_i({wa_q, wb_q, wc_q, rd25_q}), .q_o(ow31));

  assign near_x_o     = $signed(near31[0 +: CW]);
  assign near_y_o     = $signed(near31[CW +: CW]);
  assign near_z_o     = $signed(near31[2*CW +: CW]);
  assign weight_a_o   = ow31[OW-1 -: WEIGHT_W];
  assign weight_b_o   = ow31[OW-1-WEIGHT_W -: WEIGHT_W];
  assign weight_c_o   = ow31[4 +: WEIGHT_W];
  assign region_o     = ow31[3:1];
  assign degenerate_o = ow31[0];
  assign dist_sq_o    = dist_q;

endmodule

/* tb/closest_point_on_triangle_top_tb.sv */
// ----------------------------------------------------------------------------
// Closest point on triangle testbench
// Drives vertex and query transfers through the block under several idling
// phases and compares every output transfer against an exact predictor.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_top_tb
  import cpt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int WATCHDOG = 20000;
  localparam int NUM_RANDOM = 2000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [255:0] wide_t;

  typedef struct {
    coord_t v[12];
  } tri_query_t;

  typedef struct {
    coord_t near[3];
    logic [WEIGHT_W-1:0] wa, wb, wc;
    logic [DIST_W-1:0] dsq;
    logic [2:0] region;
    logic degen;
  } nearest_t;

  logic clk_i, rst_ni, valid_i, stall_o, valid_o, stall_i;
  coord_t in_v[12];
  coord_t near_x_o, near_y_o, near_z_o;
  logic [WEIGHT_W-1:0] weight_a_o, weight_b_o, weight_c_o;
  logic [DIST_W-1:0] dist_sq_o;
  logic [2:0] region_o;
  logic degenerate_o;

  nearest_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  closest_point_on_triangle_top dut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .vert_a_x_i(in_v[0]), .vert_a_y_i(in_v[1]), .vert_a_z_i(in_v[2]),
    .vert_b_x_i(in_v[3]), .vert_b_y_i(in_v[4]), .vert_b_z_i(in_v[5]),
    .vert_c_x_i(in_v[6]), .vert_c_y_i(in_v[7]), .vert_c_z_i(in_v[8]),
    .query_x_i(in_v[9]), .query_y_i(in_v[10]), .query_z_i(in_v[11]),
    .valid_o, .stall_i,
    .near_x_o, .near_y_o, .near_z_o, .weight_a_o, .weight_b_o, .weight_c_o,
    .dist_sq_o, .region_o, .degenerate_o
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // floor(num * 2^16 / den), clamped to [0, one]; den is positive.
  function automatic logic [WEIGHT_W-1:0] edge_weight(wide_t num, wide_t den);
    wide_t q;
    if (num <= 0) return 0;
    if (num >= den) return WEIGHT_ONE;
    q = (num <<< WEIGHT_BITS) / den;
    return q[WEIGHT_W-1:0];
  endfunction

  function automatic wide_t dot3(wide_t x[3], wide_t y[3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  function automatic nearest_t predict_nearest(tri_query_t t);
    wide_t a[3], b[3], c[3], p[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3], nr[3];
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, num, den, s, d;
    logic [WEIGHT_W-1:0] tw, v, w;
    region_e rg;
    nearest_t r;
    num = 0;
    den = 0;
    r.degen = 0;
    r.wa = 0;
    r.wb = 0;
    r.wc = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = t.v[i];
      b[i] = t.v[3+i];
      c[i] = t.v[6+i];
      p[i] = t.v[9+i];
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      bc[i] = c[i] - b[i];
      ap[i] = p[i] - a[i];
      bp[i] = p[i] - b[i];
      cp[i] = p[i] - c[i];
    end
    d1 = dot3(ab, ap); d2 = dot3(ac, ap);
    d3 = dot3(ab, bp); d4 = dot3(ac, bp);
    d5 = dot3(ab, cp); d6 = dot3(ac, cp);
    vc = d1 * d4 - d3 * d2;
    vb = d5 * d2 - d1 * d6;
    va = d3 * d6 - d5 * d4;
    if (d1 <= 0 && d2 <= 0) rg = RGN_A;
    else if (d3 >= 0 && d4 - d3 <= 0) rg = RGN_B;
    else if (d6 >= 0 && d5 - d6 <= 0) rg = RGN_C;
    else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      rg = RGN_AB; num = d1; den = d1 - d3;
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      rg = RGN_AC; num = d2; den = d2 - d6;
    end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
      rg = RGN_BC; num = d4 - d3; den = num + (d5 - d6);
    end else begin
      rg = RGN_FACE; den = va + vb + vc;
    end
    if (rg >= RGN_AB && den <= 0) begin
      r.degen = 1;
      rg = RGN_A;
    end
    case (rg) inside
      RGN_A: begin
        r.wa = WEIGHT_ONE; nr = a;
      end
      RGN_B: begin
        r.wb = WEIGHT_ONE; nr = b;
      end
      RGN_C: begin
        r.wc = WEIGHT_ONE; nr = c;
      end
      RGN_AB, RGN_AC, RGN_BC: begin
        tw = edge_weight(num, den);
        for (int i = 0; i < 3; i++) begin
          if (rg == RGN_AB) nr[i] = a[i] + ((wide_t'(tw) * ab[i]) >>> WEIGHT_BITS);
          else if (rg == RGN_AC) nr[i] = a[i] + ((wide_t'(tw) * ac[i]) >>> WEIGHT_BITS);
          else nr[i] = b[i] + ((wide_t'(tw) * bc[i]) >>> WEIGHT_BITS);
        end
        if (rg == RGN_AB) begin
          r.wa = WEIGHT_ONE - tw; r.wb = tw;
        end else if (rg == RGN_AC) begin
          r.wa = WEIGHT_ONE - tw; r.wc = tw;
        end else begin
          r.wb = WEIGHT_ONE - tw; r.wc = tw;
        end
      end
      default: begin
        v = edge_weight(vb, den);
        w = edge_weight(vc, den);
        if ((WEIGHT_W+1)'(v) + (WEIGHT_W+1)'(w) > (WEIGHT_W+1)'(WEIGHT_ONE))
          w = WEIGHT_ONE - v;
        r.wa = WEIGHT_ONE - v - w; r.wb = v; r.wc = w;
        for (int i = 0; i < 3; i++)
          nr[i] = a[i] + ((wide_t'(v) * ab[i] + wide_t'(w) * ac[i]) >>> WEIGHT_BITS);
      end
    endcase
    s = 0;
    for (int i = 0; i < 3; i++) begin
      d = p[i] - nr[i];
      s = s + d * d;
      r.near[i] = nr[i][CW-1:0];
    end
    // Square sum carries 32 fraction bits at Q16.16, so no rescale is needed.
    s = s >>> (2 * FB - 32);
    r.dsq = (s[255:64] != 0) ? '1 : s[63:0];
    r.region = rg;
    return r;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 32'h40000) - 32'h20000;
      default: return $urandom_range(0, 32'h1000000) - 32'h800000;
    endcase
  endfunction

  task automatic send_item(tri_query_t t);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      valid_i <= 0;
      @(posedge clk_i);
    end
    valid_i <= 1;
    for (int i = 0; i < 12; i++) in_v[i] <= t.v[i];
    expected_q.insert(expected_q.size(), predict_nearest(t));
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  // Directed rows: twelve coordinates, and for the obvious cases a typed result.
  typedef struct {
    coord_t v[12];
    bit typed;
    logic [2:0] region;
    logic degen;
  } directed_row_t;

  localparam coord_t ONE = 32'sh10000;
  localparam coord_t MAXC = 32'sh7fffffff;
  localparam coord_t MINC = -32'sh80000000;

  directed_row_t rows[] = '{
    '{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, -ONE, 0}, 1, RGN_A, 0},
    '{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 2*ONE, -ONE, 0}, 1, RGN_B, 0},
    '{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, 2*ONE, 0}, 1, RGN_C, 0},
    '{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/2, -ONE, 0}, 1, RGN_AB, 0},
    '{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, ONE/2, 0}, 1, RGN_AC, 0},
    '{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0}, 1, RGN_BC, 0},
    '{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/4, ONE/4, ONE}, 1, RGN_FACE, 0},
    '{'{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0}, 1, RGN_A, 0},
    '{'{0, 0, 0, 0, 0, 0, 2*ONE, 0, 0, ONE, ONE, 0}, 1, RGN_A, 1},
    '{'{MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MAXC, 0, MAXC, MINC, MAXC}, 0, 0, 0},
    '{'{MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, 0, MINC, MAXC, MINC}, 0, 0, 0},
    '{'{MINC, 0, 0, MAXC, 0, 0, 0, MAXC, 0, 0, 0, MAXC}, 0, 0, 0},
    '{'{-1, -1, -1, 1, 0, 0, 0, 1, 0, 0, 0, -1}, 0, 0, 0},
    '{'{MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC, MAXC, MAXC}, 0, 0, 0}
  };

  task automatic run_random(int count, int snd, int rcv);
    tri_query_t t;
    int mode;
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 2);
      for (int i = 0; i < 12; i++) t.v[i] = rand_coord(mode);
      // Occasionally collapse vertices to exercise degenerate triangles.
      if ($urandom_range(0, 19) == 0)
        for (int i = 0; i < 3; i++) t.v[6+i] = t.v[3+i];
      send_item(t);
    end
  endtask

  initial begin
    tri_query_t t;
    rst_ni = 0;
    valid_i = 0;
    stall_i = 0;
    for (int i = 0; i < 12; i++) in_v[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (rows[k]) begin
      t.v = rows[k].v;
      send_item(t);
      if (rows[k].typed) begin
        expected_q[$].region = rows[k].region;
        expected_q[$].degen = rows[k].degen;
      end
    end
    run_random(NUM_RANDOM / 4, 0, 0);
    run_random(NUM_RANDOM / 4, 77, 0);
    hold_off = 1;
    run_random(NUM_RANDOM / 4, 0, 77);
    run_random(NUM_RANDOM / 4, 34, 34);
    valid_i <= 0;
    stim_done = 1;
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  initial begin
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off && !held) begin
        held = 1;
        stall_i <= 1;
        repeat (200) @(posedge clk_i);
      end
      stall_i <= ($urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  initial begin
    nearest_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && valid_o && !stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: output transfer with nothing expected", $time);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if ({near_x_o, near_y_o, near_z_o} !== {e.near[0], e.near[1], e.near[2]}) begin
            $display("%0t: near expected %0d %0d %0d actual %0d %0d %0d", $time,
                     e.near[0], e.near[1], e.near[2], near_x_o, near_y_o, near_z_o);
            errors++;
          end
          if ({weight_a_o, weight_b_o, weight_c_o} !== {e.wa, e.wb, e.wc}) begin
            $display("%0t: weights expected %0d %0d %0d actual %0d %0d %0d", $time,
                     e.wa, e.wb, e.wc, weight_a_o, weight_b_o, weight_c_o);
            errors++;
          end
          if (dist_sq_o !== e.dsq) begin
            $display("%0t: dist_sq expected %h actual %h", $time, e.dsq, dist_sq_o);
            errors++;
          end
          if (region_o !== e.region || degenerate_o !== e.degen) begin
            $display("%0t: region/degenerate expected %0d/%0d actual %0d/%0d", $time,
                     e.region, e.degen, region_o, degenerate_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int tail;
    tail = 0;
    forever begin
      @(posedge clk_i);
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (stim_done && expected_q.size() == 0) tail++;
      if (tail == 64) begin
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
      end else if (idle_cycles >= WATCHDOG) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end
endmodule

/* files.f */
+incdir+sv
sv/cpt_pkg.sv
sv/cpt_ctrl.sv
sv/cpt_dly.sv
sv/cpt_mul.sv
sv/cpt_div.sv
sv/closest_point_on_triangle_top.sv
tb/closest_point_on_triangle_top_tb.sv
